[src/sliding_window_median_defines.svh]
// ----------------------------------------------------------------------------
// Sliding window median - assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Next-cycle implication, ignored while reset is held
`define SWM_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define SWM_ASSERT_NEXT_RST(name, trig, cons, msg) \
    name: assert property (@(posedge aclk) (trig) |=> (cons)) \
        else $error(msg);

`endif

[src/swm_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window median - package
// Sequencer states, shared-unit operations and fixed field widths.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Fixed field widths of the channels and the register
    localparam int unsigned IN_FIELD_BITS  = 16;
    localparam int unsigned MED_FIELD_BITS = 16;
    localparam int unsigned SUM_BITS       = 48;
    localparam int unsigned OUT_TDATA_BITS = MED_FIELD_BITS + SUM_BITS;
    localparam int unsigned WS_BITS        = 13;
    localparam int unsigned APB_DATA_BITS  = 32;
    localparam int unsigned APB_ADDR_BITS  = 3;

    // Register index, taken from paddr[2]
    localparam logic CFG_IDX_WINDOW_SIZE = 1'b0;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OLD,
        ST_DN_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_EMIT
    } swm_state_t;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_INC,
        ALU_DEC,
        ALU_SEL
    } swm_alu_op_t;

    // Status flags returned by the shared unit
    typedef struct packed {
        logic last_level;   // tree index is at the root of the update chain
        logic take;         // select step moves right
    } swm_alu_flags_t;

endpackage

[src/swm_ram.sv]
// ----------------------------------------------------------------------------
// Sliding window median - simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/swm_alu.sv]
// ----------------------------------------------------------------------------
// Sliding window median - shared tree unit
// Index stepping, count update and rank compare for tree update and select.
// ----------------------------------------------------------------------------
module swm_alu
    import swm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned CW          = 13
) (
    input  swm_alu_op_t             op,
    input  logic [SAMPLE_BITS:0]    base,      // tree index or select position
    input  logic [SAMPLE_BITS:0]    step,      // select step
    input  logic [CW-1:0]           mem_count, // counter read from the tree
    input  logic [CW-1:0]           rank,
    output logic [SAMPLE_BITS+1:0]  sum_idx,
    output logic [CW-1:0]           cnt_out,
    output swm_alu_flags_t          flags
);

    localparam int unsigned IW          = SAMPLE_BITS + 1;
    localparam int unsigned VALUE_COUNT = 1 << SAMPLE_BITS;

    logic [IW-1:0] lowbit;
    logic [IW-1:0] addend;

    // Index adder: parent step for updates, position plus step for select
    always_comb begin
        lowbit  = base & (~base + IW'(1));
        addend  = (op == ALU_SEL) ? step : lowbit;
        sum_idx = {1'b0, base} + {1'b0, addend};
    end

    // Counter arithmetic
    always_comb begin
        unique case (op)
            ALU_INC: cnt_out = mem_count + CW'(1);
            ALU_DEC: cnt_out = mem_count - CW'(1);
            ALU_SEL: cnt_out = rank - mem_count;
            default: cnt_out = mem_count;
        endcase
    end

    assign flags.last_level = (base == IW'(VALUE_COUNT));
    assign flags.take       = (sum_idx <= (IW + 1)'(VALUE_COUNT)) && (mem_count < rank);

endmodule

[src/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// Sliding window median - top level
// Histogram tree median filter over the last K samples with a running sum.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream channel, one item at a time. Each sample
//   evicts the oldest one once K samples are held; from the K-th sample on,
//   each item produces one result on the m_ channel: the lower median of the
//   window and the running median sum (mod 2^48).
//   Per item: one window read, a histogram decrement walk, an increment walk
//   and a rank descent, all through one shared unit and one tree RAM port.
//   The walk lengths depend on the sample values; items that only fill the
//   window skip the decrement walk and the rank descent. s_tready stays low
//   until the item is done.
//   The result sits in an output register; a stalled receiver holds it and
//   the next item is accepted, but its result waits until the slot is free.
//   Reset and every write of window_size clear the histogram with a pass over
//   all 2^SAMPLE_BITS entries during which no item is accepted; the write
//   pointer, fill count and sum are cleared at once.
// ----------------------------------------------------------------------------
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned WINDOW_MAX  = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_FIELD_BITS-1:0]  s_tdata,   // [15:0] sample
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [15:0] median, [63:16] median_sum
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    localparam int unsigned B           = SAMPLE_BITS;
    localparam int unsigned IW          = B + 1;
    localparam int unsigned CW          = $clog2(WINDOW_MAX + 1);
    localparam int unsigned PW          = $clog2(WINDOW_MAX);
    localparam int unsigned VALUE_COUNT = 1 << B;

    // State
    swm_state_t          state_reg, state_next;
    logic [B-1:0]        clr_reg, clr_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [WS_BITS-1:0]  ws_reg, ws_next;
    logic                out_valid_reg, out_valid_next;

    // Per-item working registers
    logic [B-1:0]              sample_reg, sample_next;
    logic [PW-1:0]             slot_reg, slot_next;
    logic                      emit_reg, emit_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic [IW-1:0]             step_reg, step_next;
    logic [CW-1:0]             rank_reg, rank_next;
    logic [OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    // Derived control values
    logic [CW-1:0]  k_eff;
    logic [PW-1:0]  wp_eff;
    logic [CW:0]    wp_inc;
    logic [CW:0]    fill_inc;
    logic           evict;
    logic [CW-1:0]  rank_init;
    logic           in_fire;
    logic           cfg_hit;
    logic [B-1:0]   med;
    logic [SUM_BITS-1:0] sum_add;

    // Memory ports
    logic          t_we;
    logic [B-1:0]  t_waddr, t_raddr;
    logic [CW-1:0] t_wdata, t_rdata;
    logic          w_we;
    logic [PW-1:0] w_raddr;
    logic [B-1:0]  w_rdata;

    // Shared unit
    swm_alu_op_t    alu_op;
    logic [IW-1:0]  alu_base;
    logic [IW:0]    alu_sum;
    logic [CW-1:0]  alu_cnt;
    swm_alu_flags_t alu_flags;
    logic [IW:0]    alu_sum_m1;
    logic [IW-1:0]  idx_m1;

    // Histogram tree, entry i-1 holds tree node i
    swm_ram #(
        .WIDTH (CW),
        .DEPTH (VALUE_COUNT)
    ) u_tree_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // Delay line of window samples
    swm_ram #(
        .WIDTH (B),
        .DEPTH (WINDOW_MAX)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    swm_alu #(
        .SAMPLE_BITS (B),
        .CW          (CW)
    ) u_alu (
        .op        (alu_op),
        .base      (alu_base),
        .step      (step_reg),
        .mem_count (t_rdata),
        .rank      (rank_reg),
        .sum_idx   (alu_sum),
        .cnt_out   (alu_cnt),
        .flags     (alu_flags)
    );

    // Effective window length, write slot and fill status
    always_comb begin
        if (ws_reg == '0) begin
            k_eff = CW'(1);
        end else if (32'(ws_reg) > WINDOW_MAX) begin
            k_eff = CW'(WINDOW_MAX);
        end else begin
            k_eff = CW'(ws_reg);
        end
        wp_eff    = (CW'(wp_reg) >= k_eff) ? '0 : wp_reg;
        wp_inc    = {1'b0, CW'(wp_eff)} + (CW + 1)'(1);
        fill_inc  = {1'b0, fill_reg} + (CW + 1)'(1);
        evict     = (fill_reg >= k_eff);
        rank_init = CW'(({1'b0, k_eff} + (CW + 1)'(1)) >> 1);
        med       = pos_reg[B] ? '1 : pos_reg[B-1:0];
        sum_add   = sum_reg + SUM_BITS'(med);
    end

    assign in_fire    = s_tvalid && s_tready;
    assign cfg_hit    = psel && penable && pwrite && pready
                        && (paddr[2] == CFG_IDX_WINDOW_SIZE);
    assign alu_sum_m1 = alu_sum - (IW + 1)'(1);
    assign idx_m1     = idx_reg - IW'(1);

    // Shared unit operand selection
    always_comb begin
        unique case (state_reg)
            ST_DN_WR: begin
                alu_op   = ALU_DEC;
                alu_base = idx_reg;
            end
            ST_UP_WR: begin
                alu_op   = ALU_INC;
                alu_base = idx_reg;
            end
            default: begin
                alu_op   = ALU_SEL;
                alu_base = pos_reg;
            end
        endcase
    end

    // Sequencer: next state, memory controls and register updates
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        ws_next        = ws_reg;
        out_valid_next = out_valid_reg && !m_tready;
        sample_next    = sample_reg;
        slot_next      = slot_reg;
        emit_next      = emit_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        rank_next      = rank_reg;
        out_data_next  = out_data_reg;
        t_we           = 1'b0;
        t_waddr        = idx_m1[B-1:0];
        t_wdata        = alu_cnt;
        t_raddr        = alu_sum_m1[B-1:0];
        w_we           = 1'b0;
        w_raddr        = slot_reg;
        s_tready       = 1'b0;

        unique case (state_reg)
            // zero one tree entry per cycle
            ST_CLEAR: begin
                t_we     = 1'b1;
                t_waddr  = clr_reg;
                t_wdata  = '0;
                clr_next = clr_reg + B'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            // take an item, start reading the oldest sample
            ST_IDLE: begin
                s_tready = 1'b1;
                w_raddr  = wp_eff;
                if (in_fire) begin
                    sample_next = s_tdata[B-1:0];
                    slot_next   = wp_eff;
                    wp_next     = (wp_inc >= {1'b0, k_eff}) ? '0 : PW'(wp_inc);
                    emit_next   = evict || (fill_inc >= {1'b0, k_eff});
                    if (evict) begin
                        state_next = ST_OLD;
                    end else begin
                        fill_next  = CW'(fill_inc);
                        state_next = ST_UP_RD;
                    end
                end
            end
            // oldest sample available, read its first tree node
            ST_OLD: begin
                t_raddr    = w_rdata;
                idx_next   = {1'b0, w_rdata} + IW'(1);
                state_next = ST_DN_WR;
            end
            // decrement walk: write node, read the next one
            ST_DN_WR: begin
                t_we = 1'b1;
                if (alu_flags.last_level) begin
                    state_next = ST_UP_RD;
                end else begin
                    idx_next = alu_sum[IW-1:0];
                end
            end
            // store the new sample, read its first tree node
            ST_UP_RD: begin
                w_we       = 1'b1;
                t_raddr    = sample_reg;
                idx_next   = {1'b0, sample_reg} + IW'(1);
                state_next = ST_UP_WR;
            end
            // increment walk
            ST_UP_WR: begin
                t_we = 1'b1;
                if (alu_flags.last_level) begin
                    if (emit_reg) begin
                        pos_next   = '0;
                        step_next  = IW'(VALUE_COUNT);
                        rank_next  = rank_init;
                        state_next = ST_SEL_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    idx_next = alu_sum[IW-1:0];
                end
            end
            // rank descent: read node at position plus step
            ST_SEL_RD: begin
                state_next = ST_SEL_CMP;
            end
            ST_SEL_CMP: begin
                if (alu_flags.take) begin
                    pos_next  = alu_sum[IW-1:0];
                    rank_next = alu_cnt;
                end
                step_next = step_reg >> 1;
                if (step_reg == IW'(1)) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SEL_RD;
                end
            end
            // load the output register once it is free
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    sum_next       = sum_add;
                    out_data_next  = {sum_add, MED_FIELD_BITS'(med)};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        // window_size write restarts the filter
        if (cfg_hit) begin
            ws_next    = pwdata[WS_BITS-1:0];
            state_next = ST_CLEAR;
            clr_next   = '0;
            wp_next    = '0;
            fill_next  = '0;
            sum_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            ws_reg        <= WS_BITS'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            ws_reg        <= ws_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        slot_reg     <= slot_next;
        emit_reg     <= emit_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        step_reg     <= step_next;
        rank_reg     <= rank_next;
        out_data_reg <= out_data_next;
    end

    // Outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == CFG_IDX_WINDOW_SIZE)
                      ? {{(APB_DATA_BITS - WS_BITS){1'b0}}, ws_reg} : '0;

endmodule

[src/swm_checker.sv]
// ----------------------------------------------------------------------------
// Sliding window median - port checker
// Port-level properties of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sliding_window_median_defines.svh"

module swm_checker
    import swm_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_TDATA_BITS-1:0] m_tdata,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [APB_ADDR_BITS-1:0]  paddr
);

    // a stalled result holds
    `SWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // reset starts the histogram clear, no item taken
    `SWM_ASSERT_NEXT_RST(a_reset_clear, !aresetn, !s_tready, "item taken right after reset")

    // one item at a time
    `SWM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "ready right after an accepted item")

    // a window_size write restarts with a clear pass
    `SWM_ASSERT_NEXT(a_cfg_restart, psel && penable && pwrite && (paddr[2] == CFG_IDX_WINDOW_SIZE), !s_tready, "ready right after a window_size write")

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Sliding window median - block testbench
// Feeds sample streams through several window lengths, from the smallest to
// the largest and clamped ones, and checks every median and running sum
// against a histogram-tree predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
    import swm_pkg::*;

    localparam int unsigned VALUE_SPAN     = 1 << IN_FIELD_BITS;
    localparam int unsigned WINDOW_LIMIT   = 4096;
    localparam int unsigned WATCHDOG_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned RANDOM_ITEMS   = 622;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_SIZE = {CFG_IDX_WINDOW_SIZE, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] ADDR_NO_REG      = {~CFG_IDX_WINDOW_SIZE, 2'b00};

    typedef struct packed {
        logic [SUM_BITS-1:0]       msum;
        logic [MED_FIELD_BITS-1:0] median;
    } median_result_t;

    // Predicts medians from accepted samples and checks results in order
    class median_scoreboard;
        logic [WS_BITS-1:0]       window_reg;
        int unsigned              rank_tree[VALUE_SPAN+1];
        logic [IN_FIELD_BITS-1:0] delay_line[WINDOW_LIMIT];
        int unsigned              wr_ptr;
        int unsigned              filled;
        logic [SUM_BITS-1:0]      running_sum;
        median_result_t           pending[$];
        int unsigned              mismatches;
        int unsigned              medians_checked;
        int unsigned              samples_taken;

        function new();
            window_reg = WS_BITS'(1);
            clear_history();
        endfunction

        function void clear_history();
            foreach (rank_tree[i]) rank_tree[i] = 0;
            wr_ptr      = 0;
            filled      = 0;
            running_sum = '0;
        endfunction

        // 0 behaves as 1, anything above the delay line size is clamped
        function int unsigned window_len();
            if (window_reg == 0) return 1;
            if (window_reg > WINDOW_LIMIT) return WINDOW_LIMIT;
            return 32'(window_reg);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void write_reg(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] data);
            if (addr[2] != CFG_IDX_WINDOW_SIZE) return;
            window_reg = data[WS_BITS-1:0];
            clear_history();
        endfunction

        function void tree_bump(logic [IN_FIELD_BITS-1:0] v, bit add);
            int unsigned idx;
            idx = v + 1;
            while (idx <= VALUE_SPAN) begin
                if (add) rank_tree[idx]++;
                else rank_tree[idx]--;
                idx += idx & (~idx + 1);
            end
        endfunction

        // smallest value whose cumulative count reaches the rank
        function logic [IN_FIELD_BITS-1:0] rank_lookup(int unsigned rank);
            int unsigned pos;
            int unsigned stride;
            pos    = 0;
            stride = VALUE_SPAN;
            while (stride > 0) begin
                if (pos + stride <= VALUE_SPAN && rank_tree[pos + stride] < rank) begin
                    pos  += stride;
                    rank -= rank_tree[pos];
                end
                stride >>= 1;
            end
            if (pos > VALUE_SPAN - 1) pos = VALUE_SPAN - 1;
            return pos[IN_FIELD_BITS-1:0];
        endfunction

        function void note_sample(logic [IN_FIELD_BITS-1:0] s);
            int unsigned    k;
            int unsigned    slot;
            median_result_t res;
            k = window_len();
            slot = (wr_ptr >= k) ? 0 : wr_ptr;
            samples_taken++;
            // evict the oldest sample once the window is full
            if (filled >= k) tree_bump(delay_line[slot], 1'b0);
            else filled++;
            tree_bump(s, 1'b1);
            delay_line[slot] = s;
            slot++;
            wr_ptr = (slot >= k) ? 0 : slot;
            if (filled < k) return;
            res.median  = rank_lookup((k + 1) / 2);
            running_sum = running_sum + res.median;
            res.msum    = running_sum;
            pending.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_BITS-1:0] tdata);
            median_result_t want;
            median_result_t got;
            got = tdata;
            if (pending.size() == 0) begin
                flag($sformatf("unexpected result: median %0d sum %0d", got.median, got.msum));
                return;
            end
            want = pending.pop_front();
            medians_checked++;
            if (got.median !== want.median)
                flag($sformatf("median mismatch at result %0d: expected %0d, got %0d",
                               medians_checked, want.median, got.median));
            if (got.msum !== want.msum)
                flag($sformatf("median_sum mismatch at result %0d: expected %0d, got %0d",
                               medians_checked, want.msum, got.msum));
        endfunction
    endclass

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_FIELD_BITS-1:0]  s_tdata  = '0;   // [15:0] sample
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;         // [15:0] median, [63:16] median_sum
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr    = '0;
    logic [APB_DATA_BITS-1:0]  pwdata   = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    median_scoreboard sb = new();

    int unsigned send_idle_pct  = 14;
    int unsigned recv_idle_pct  = 84;
    int unsigned settings_tried = 1;
    int unsigned idle_cycles    = 0;
    logic [IN_FIELD_BITS-1:0] cluster_base = 16'h4000;

    sliding_window_median dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Accepted items go to the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
            if (psel && penable && pwrite && pready) sb.write_reg(paddr, pwdata);
        end
    end

    // Watchdog: long stretches with no accepted item end the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("sliding_window_median test failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Random sample: full range, clustered values or near the extremes
    function automatic logic [IN_FIELD_BITS-1:0] pick_sample();
        case ($urandom_range(3))
            0, 1:    return IN_FIELD_BITS'($urandom);
            2:       return IN_FIELD_BITS'(cluster_base + $urandom_range(15));
            default: return IN_FIELD_BITS'(($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                           ^ $urandom_range(1));
        endcase
    endfunction

    task automatic send_sample(logic [IN_FIELD_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk) s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic apb_write(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk) penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            sb.flag($sformatf("window_size readback: expected %0d, got %0d", want, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop sending, wait for every expected result, then let the block go idle
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(logic [APB_DATA_BITS-1:0] data);
        apb_write(ADDR_WINDOW_SIZE, data);
        apb_read_check(ADDR_WINDOW_SIZE, APB_DATA_BITS'(data[WS_BITS-1:0]));
        settings_tried++;
    endtask

    task automatic run_window(logic [APB_DATA_BITS-1:0] data, int unsigned count);
        set_window(data);
        cluster_base = IN_FIELD_BITS'($urandom);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 97 == 0) cluster_base = IN_FIELD_BITS'($urandom);
            send_sample(pick_sample());
        end
        settle();
    endtask

    initial begin
        logic [IN_FIELD_BITS-1:0] edge_samples[7];
        logic [IN_FIELD_BITS-1:0] pair_samples[5];
        logic [IN_FIELD_BITS-1:0] dup_samples[6];
        edge_samples = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF};
        pair_samples = '{16'd100, 16'd50, 16'd50, 16'hFFFF, 16'h0000};
        dup_samples  = '{16'd5, 16'd5, 16'd5, 16'd1, 16'hFFFF, 16'hFFFF};

        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Reset window of one: every sample is its own median
        foreach (edge_samples[i]) send_sample(edge_samples[i]);
        settle();

        // Zero acts as a window of one
        set_window(0);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'd12345);
        settle();

        // Window of two: lower median is the smaller sample, with evictions
        set_window(2);
        foreach (pair_samples[i]) send_sample(pair_samples[i]);
        settle();

        // A write to an unmapped address must not restart the filter
        apb_write(ADDR_NO_REG, 7);
        apb_read_check(ADDR_WINDOW_SIZE, 2);
        send_sample(16'd7);
        send_sample(16'd9);
        send_sample(16'd9);
        settle();

        // Bits above the register width are dropped: window of three, duplicates
        set_window(32'hFFFF_E003);
        foreach (dup_samples[i]) send_sample(dup_samples[i]);
        settle();

        // Random phases, sender rarely idle and receiver mostly stalled
        run_window(5, RANDOM_ITEMS);

        // Sender mostly idle, receiver rarely stalled
        send_idle_pct = 84;
        recv_idle_pct = 14;
        run_window(64, RANDOM_ITEMS);
        // Largest legal window, too short to fill: no result may appear
        run_window(WINDOW_LIMIT, 30);

        // No idling: clamped window, too short to fill, then a small window
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_window(13'h1FFF, 30);
        run_window(9, RANDOM_ITEMS);

        $display("covered %0d samples and %0d medians over %0d window settings",
                 sb.samples_taken, sb.medians_checked, settings_tried);
        $display("windows of 1, 2, 3, 5, 9, 64 and 4096, with zero and oversize values");
        if (sb.mismatches == 0) begin
            $display("sliding_window_median test passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("sliding_window_median test failed");
        end
        $finish;
    end

endmodule
